// ===== sv/point_in_triangle_sweep_core_defines.svh =====
// Assertion macros for the triangle sweep core.
// Defining NO_ASSERTIONS turns every use into empty text.
`ifndef POINT_IN_TRIANGLE_SWEEP_CORE_DEFINES_SVH
`define POINT_IN_TRIANGLE_SWEEP_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PITS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PITS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PITS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define PITS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/pits_pkg.sv =====
`default_nettype none

package pits_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int CROSS_W     = PROD_W + 1;
   // Each cross component is split into a signed upper part and an unsigned lower part.
   localparam int LO_W        = CROSS_W / 2;
   localparam int HI_W        = CROSS_W - LO_W;
   localparam int MIX_W       = HI_W + LO_W + 1;
   localparam int TERM_W      = 2 * CROSS_W;
   localparam int DOT_W       = TERM_W + 2;

   // Register stages from request to result strobe.
   localparam int PIPE_DEPTH  = 7;

   // Point indexes: vertices A, B, C and the query point Q.
   localparam int PT_A = 0;
   localparam int PT_B = 1;
   localparam int PT_C = 2;
   localparam int PT_Q = 3;

   // Difference vectors: A-Q, B-A, B-Q, C-B, C-Q, A-C.
   localparam int DIFF_MIN [6] = '{PT_A, PT_B, PT_B, PT_C, PT_C, PT_A};
   localparam int DIFF_SUB [6] = '{PT_Q, PT_A, PT_Q, PT_B, PT_Q, PT_C};

   // Cyclic neighbours of each axis, used by the cross product.
   localparam int AX_NEXT [3] = '{1, 2, 0};
   localparam int AX_PREV [3] = '{2, 0, 1};

   // Dot product pairs of cross vectors: c0.c1, c0.c2, c1.c2.
   localparam int DOT_L [3] = '{0, 0, 1};
   localparam int DOT_R [3] = '{1, 2, 2};

endpackage

`default_nettype wire

// ===== sv/point_in_triangle_sweep_core.sv =====
// Point against triangle sweep test, by cross product signs.
//
// A request carries three vertices and a query point on req_*; it is taken at
// a rising edge where start is high and busy is low. busy is high only while
// reset is applied, so one request can be taken in every cycle.
// The block forms c0 = (A-Q)x(B-A), c1 = (B-Q)x(C-B), c2 = (C-Q)x(A-C), the dot
// products c0.c1, c0.c2 and c1.c2, and reports inside when all three have the
// same sign (negative, zero and positive being three signs). All arithmetic is
// exact.
// The result for a request taken at an edge shows on rsp_inside_res with
// rsp_valid high for a single cycle, once it has passed every pipeline stage.
// Throughput is one request per cycle, set by a seven stage pipeline:
// differences, cross products, cross sums, split dot multiplies, term
// recombination, dot sums and sign compare.
// Results are never held back: the receiver must take each one in its cycle.
// Synchronous reset empties the pipeline; requests in flight are dropped.
`default_nettype none
`include "point_in_triangle_sweep_core_defines.svh"

module point_in_triangle_sweep_core
   import pits_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_a_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_a_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_a_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_b_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_b_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_b_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_c_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_c_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_c_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_q_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_q_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_q_z,
   output logic                               rsp_valid,
   output logic                               rsp_inside_res
);

   logic                        accept;
   logic [PIPE_DEPTH-2:0]       vld_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_inside_ff;
   logic                        rsp_inside_in;

   logic signed [COORD_WIDTH-1:0] pt [4][3];

   logic signed [DIFF_W-1:0]  diff_in   [6][3];
   logic signed [DIFF_W-1:0]  diff_ff   [6][3];
   logic signed [PROD_W-1:0]  prod_in   [3][6];
   logic signed [PROD_W-1:0]  prod_ff   [3][6];
   logic signed [CROSS_W-1:0] cross_in  [3][3];
   logic signed [CROSS_W-1:0] cross_ff  [3][3];
   logic signed [2*HI_W-1:0]  pp_hh_in  [3][3];
   logic signed [2*HI_W-1:0]  pp_hh_ff  [3][3];
   logic signed [MIX_W-1:0]   pp_hl_in  [3][3];
   logic signed [MIX_W-1:0]   pp_hl_ff  [3][3];
   logic signed [MIX_W-1:0]   pp_lh_in  [3][3];
   logic signed [MIX_W-1:0]   pp_lh_ff  [3][3];
   logic [2*LO_W-1:0]         pp_ll_in  [3][3];
   logic [2*LO_W-1:0]         pp_ll_ff  [3][3];
   logic signed [TERM_W-1:0]  term_in   [3][3];
   logic signed [TERM_W-1:0]  term_ff   [3][3];
   logic signed [DOT_W-1:0]   dot_in    [3];
   logic signed [DOT_W-1:0]   dot_ff    [3];

   logic signed [HI_W-1:0]    hi_l;
   logic signed [HI_W-1:0]    hi_r;
   logic signed [LO_W:0]      lo_l;
   logic signed [LO_W:0]      lo_r;
   logic [LO_W-1:0]           lo_l_u;
   logic [LO_W-1:0]           lo_r_u;
   logic [2:0]                dot_neg;
   logic [2:0]                dot_zero;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      pt[PT_A][0] = req_a_x;
      pt[PT_A][1] = req_a_y;
      pt[PT_A][2] = req_a_z;
      pt[PT_B][0] = req_b_x;
      pt[PT_B][1] = req_b_y;
      pt[PT_B][2] = req_b_z;
      pt[PT_C][0] = req_c_x;
      pt[PT_C][1] = req_c_y;
      pt[PT_C][2] = req_c_z;
      pt[PT_Q][0] = req_q_x;
      pt[PT_Q][1] = req_q_y;
      pt[PT_Q][2] = req_q_z;
   end

   // Stage 1: the six difference vectors.
   always_comb begin
      for (int v = 0; v < 6; v++) begin
         for (int ax = 0; ax < 3; ax++) begin
            diff_in[v][ax] = DIFF_W'(pt[DIFF_MIN[v]][ax]) - DIFF_W'(pt[DIFF_SUB[v]][ax]);
         end
      end
   end

   // Stage 2: the eighteen products of the three cross products.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int ax = 0; ax < 3; ax++) begin
            prod_in[k][2*ax]   = diff_ff[2*k][AX_NEXT[ax]] * diff_ff[2*k+1][AX_PREV[ax]];
            prod_in[k][2*ax+1] = diff_ff[2*k][AX_PREV[ax]] * diff_ff[2*k+1][AX_NEXT[ax]];
         end
      end
   end

   // Stage 3: cross components.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int ax = 0; ax < 3; ax++) begin
            cross_in[k][ax] = CROSS_W'(prod_ff[k][2*ax]) - CROSS_W'(prod_ff[k][2*ax+1]);
         end
      end
   end

   // Stage 4: each wide component product is cut into four narrow partial products.
   always_comb begin
      hi_l   = '0;
      hi_r   = '0;
      lo_l_u = '0;
      lo_r_u = '0;
      lo_l   = '0;
      lo_r   = '0;
      for (int d = 0; d < 3; d++) begin
         for (int ax = 0; ax < 3; ax++) begin
            hi_l   = cross_ff[DOT_L[d]][ax][CROSS_W-1:LO_W];
            hi_r   = cross_ff[DOT_R[d]][ax][CROSS_W-1:LO_W];
            lo_l_u = cross_ff[DOT_L[d]][ax][LO_W-1:0];
            lo_r_u = cross_ff[DOT_R[d]][ax][LO_W-1:0];
            lo_l   = $signed({1'b0, lo_l_u});
            lo_r   = $signed({1'b0, lo_r_u});
            pp_hh_in[d][ax] = hi_l * hi_r;
            pp_hl_in[d][ax] = hi_l * lo_r;
            pp_lh_in[d][ax] = lo_l * hi_r;
            pp_ll_in[d][ax] = lo_l_u * lo_r_u;
         end
      end
   end

   // Stage 5: partial products shifted back into place.
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         for (int ax = 0; ax < 3; ax++) begin
            term_in[d][ax] = (TERM_W'(pp_hh_ff[d][ax]) <<< (2 * LO_W))
                           + (TERM_W'(pp_hl_ff[d][ax]) <<< LO_W)
                           + (TERM_W'(pp_lh_ff[d][ax]) <<< LO_W)
                           + TERM_W'(pp_ll_ff[d][ax]);
         end
      end
   end

   // Stage 6: dot product sums.
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         dot_in[d] = DOT_W'(term_ff[d][0]) + DOT_W'(term_ff[d][1]) + DOT_W'(term_ff[d][2]);
      end
   end

   // Stage 7: three-way sign compare. Zero excludes negative, so equal neg and
   // zero flags mean equal signs.
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         dot_neg[d]  = dot_ff[d][DOT_W-1];
         dot_zero[d] = (dot_ff[d] == '0);
      end
      rsp_inside_in = (dot_neg[0] == dot_neg[1]) && (dot_neg[0] == dot_neg[2])
                   && (dot_zero[0] == dot_zero[1]) && (dot_zero[0] == dot_zero[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-3:0], accept};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-2];
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      cross_ff      <= cross_in;
      pp_hh_ff      <= pp_hh_in;
      pp_hl_ff      <= pp_hl_in;
      pp_lh_ff      <= pp_lh_in;
      pp_ll_ff      <= pp_ll_in;
      term_ff       <= term_in;
      dot_ff        <= dot_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   `PITS_ASSERT_IMPLIES(a_no_invented_result, clock, reset, rsp_valid, $past(vld_ff[PIPE_DEPTH-2]), "result strobe without a request in the last stage")
   `PITS_ASSERT_NEXT(a_degenerate_inside, clock, reset, vld_ff[PIPE_DEPTH-2] && dot_ff[0] == '0 && dot_ff[1] == '0 && dot_ff[2] == '0, rsp_valid && rsp_inside_res, "all-zero dot products must report inside")
   `PITS_ASSERT_NEXT(a_mixed_signs_outside, clock, reset, vld_ff[PIPE_DEPTH-2] && dot_ff[0][DOT_W-1] != dot_ff[1][DOT_W-1], rsp_valid && !rsp_inside_res, "opposite dot signs must report outside")

endmodule

`default_nettype wire
